// ===== design/elba_pkg.sv =====
// Shared types and codes for the extent list block allocator.
// Holds the operation and status codes, the word structs and the sequencer states.
// No dependencies.
`default_nettype none

package elba_pkg;

	// Operation codes carried in the op field.
	localparam logic [1:0] OP_INIT  = 2'd0;
	localparam logic [1:0] OP_ALLOC = 2'd1;
	localparam logic [1:0] OP_FREE  = 2'd2;

	// Status codes returned with every result word.
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_BAD_GROUP = 3'd1;
	localparam logic [2:0] ST_NO_SPACE  = 3'd2;
	localparam logic [2:0] ST_FULL      = 3'd3;
	localparam logic [2:0] ST_BAD_RANGE = 3'd4;

	localparam int unsigned EXT_W = 64;

	// One free extent as it sits in the extent memory.
	typedef struct packed {
		logic [31:0] start;
		logic [31:0] len;
	} extent_t;

	// One request word as accepted on the input channel.
	typedef struct packed {
		logic [1:0]  op;
		logic [3:0]  ag_index;
		logic [31:0] block_number;
		logic [31:0] group_size;
	} req_t;

	// One result word handed to the output register.
	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] alloc_block;
		logic [31:0] free_count;
	} result_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		SQ_IDLE,
		SQ_DISPATCH,
		SQ_SCAN_RD,
		SQ_SCAN_CHK,
		SQ_SHIFT_RD,
		SQ_SHIFT_WR,
		SQ_RESP
	} seq_state_t;

endpackage

`default_nettype wire

// ===== design/elba_ext_ram.sv =====
// Extent memory: one write port and one read port, read data registered.
// Depends on elba_pkg for the entry width.
`default_nettype none

module elba_ext_ram #(
	parameter int unsigned DEPTH = 256,
	parameter int unsigned AW    = 8
) (
	input  wire                      clk,
	input  wire                      we,
	input  wire  [AW-1:0]            waddr,
	input  wire  [elba_pkg::EXT_W-1:0] wdata,
	input  wire                      re,
	input  wire  [AW-1:0]            raddr,
	output logic [elba_pkg::EXT_W-1:0] rdata
);
	import elba_pkg::*;

	logic [EXT_W-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port with registered read data.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== design/elba_seq.sv =====
// Allocator sequencer: per-group extent counts, the global free counter and
// the read-modify-write walk over the extent memory. Depends on elba_pkg.
`default_nettype none

module elba_seq #(
	parameter int unsigned GROUP_COUNT = 4,
	parameter int unsigned MAX_EXTENTS = 64,
	parameter int unsigned AW          = 8
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        start,
	input  elba_pkg::req_t             req,
	output logic                       idle,
	output logic                       res_valid,
	input  wire                        res_ready,
	output elba_pkg::result_t          res,
	input  wire                        cfg_wr_en,
	input  wire  [31:0]                cfg_wr_data,
	output logic                       mem_we,
	output logic [AW-1:0]              mem_waddr,
	output logic [elba_pkg::EXT_W-1:0] mem_wdata,
	output logic                       mem_re,
	output logic [AW-1:0]              mem_raddr,
	input  wire  [elba_pkg::EXT_W-1:0] mem_rdata
);
	import elba_pkg::*;

	localparam int unsigned IW = $clog2(MAX_EXTENTS);
	localparam int unsigned CW = $clog2(MAX_EXTENTS + 1);
	localparam int unsigned XW = CW + 1;
	localparam int unsigned GW = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;

	seq_state_t state_q, state_d;

	req_t        req_q;
	logic [IW-1:0] idx_q;
	logic [2:0]  status_q;
	logic [31:0] blk_q;
	logic [31:0] fc_q;
	logic [CW-1:0] cnt_q [GROUP_COUNT];

	logic [GW-1:0] grp;
	logic [CW-1:0] cur_n;
	logic [XW-1:0] n_x, idx_x;
	extent_t     rd;
	logic        bad_group, init_bad, list_full, list_empty;
	logic        hit, last_blk, scan_more;

	logic        st_ld;
	logic [2:0]  st_val;
	logic        blk_ld;
	logic [31:0] blk_val;
	logic        idx_clr, idx_inc;
	logic        cnt_we;
	logic [CW-1:0] cnt_val;
	logic        fc_inc, fc_dec;
	extent_t     wr_ext;

	// Decode of the held request and of the word just read.
	always_comb begin
		grp        = req_q.ag_index[GW-1:0];
		cur_n      = cnt_q[grp];
		n_x        = XW'(cur_n);
		idx_x      = XW'(idx_q);
		rd         = extent_t'(mem_rdata);
		bad_group  = {1'b0, req_q.ag_index} >= 5'(GROUP_COUNT);
		init_bad   = req_q.group_size < req_q.block_number;
		list_full  = n_x >= XW'(MAX_EXTENTS);
		list_empty = (cur_n == '0);
		hit        = (rd.len != 32'd0);
		last_blk   = (rd.len == 32'd1);
		scan_more  = (idx_x + XW'(1)) < n_x;
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			SQ_IDLE: begin
				if (start) state_d = SQ_DISPATCH;
			end
			SQ_DISPATCH: begin
				if (req_q.op == OP_ALLOC && !bad_group && !list_empty) state_d = SQ_SCAN_RD;
				else state_d = SQ_RESP;
			end
			SQ_SCAN_RD: state_d = SQ_SCAN_CHK;
			SQ_SCAN_CHK: begin
				if (hit) begin
					state_d = (last_blk && scan_more) ? SQ_SHIFT_RD : SQ_RESP;
				end else begin
					state_d = scan_more ? SQ_SCAN_RD : SQ_RESP;
				end
			end
			SQ_SHIFT_RD: state_d = SQ_SHIFT_WR;
			// The count already holds the shortened length here, so the shift goes
			// on while the slot after the one just written is still inside the list.
			SQ_SHIFT_WR: state_d = scan_more ? SQ_SHIFT_RD : SQ_RESP;
			SQ_RESP: begin
				if (res_ready) state_d = SQ_IDLE;
			end
			default: state_d = SQ_IDLE;
		endcase
	end

	// Outputs and datapath controls per state.
	always_comb begin
		idle      = 1'b0;
		res_valid = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = {grp, idx_q};
		wr_ext    = rd;
		mem_re    = 1'b0;
		mem_raddr = {grp, idx_q};
		st_ld     = 1'b0;
		st_val    = ST_OK;
		blk_ld    = 1'b0;
		blk_val   = 32'd0;
		idx_clr   = 1'b0;
		idx_inc   = 1'b0;
		cnt_we    = 1'b0;
		cnt_val   = cur_n;
		fc_inc    = 1'b0;
		fc_dec    = 1'b0;
		case (state_q)
			SQ_IDLE: idle = 1'b1;
			SQ_DISPATCH: begin
				st_ld   = 1'b1;
				blk_ld  = 1'b1;
				idx_clr = 1'b1;
				if (req_q.op == OP_INIT || req_q.op == OP_ALLOC || req_q.op == OP_FREE) begin
					if (bad_group) begin
						st_val = ST_BAD_GROUP;
					end else begin
						case (req_q.op)
							OP_INIT: begin
								if (init_bad) begin
									st_val = ST_BAD_RANGE;
								end else begin
									// One extent from the first free block to the group end.
									mem_we       = 1'b1;
									mem_waddr    = {grp, IW'(0)};
									wr_ext.start = req_q.block_number;
									wr_ext.len   = req_q.group_size - req_q.block_number;
									cnt_we       = 1'b1;
									cnt_val      = CW'(1);
								end
							end
							OP_ALLOC: begin
								if (list_empty) st_val = ST_NO_SPACE;
							end
							OP_FREE: begin
								if (list_full) begin
									st_val = ST_FULL;
								end else begin
									// Append a one-block extent after the last entry.
									mem_we       = 1'b1;
									mem_waddr    = {grp, cur_n[IW-1:0]};
									wr_ext.start = req_q.block_number;
									wr_ext.len   = 32'd1;
									cnt_we       = 1'b1;
									cnt_val      = cur_n + CW'(1);
									fc_inc       = 1'b1;
								end
							end
							default: st_val = ST_OK;
						endcase
					end
				end
			end
			SQ_SCAN_RD: mem_re = 1'b1;
			SQ_SCAN_CHK: begin
				if (hit) begin
					blk_ld  = 1'b1;
					blk_val = rd.start;
					fc_dec  = 1'b1;
					if (last_blk) begin
						// Extent exhausted: later entries shift down one place.
						cnt_we  = 1'b1;
						cnt_val = cur_n - CW'(1);
					end else begin
						mem_we       = 1'b1;
						wr_ext.start = rd.start + 32'd1;
						wr_ext.len   = rd.len - 32'd1;
					end
				end else if (scan_more) begin
					idx_inc = 1'b1;
				end else begin
					st_ld  = 1'b1;
					st_val = ST_NO_SPACE;
				end
			end
			SQ_SHIFT_RD: begin
				mem_re    = 1'b1;
				mem_raddr = {grp, IW'(idx_x + XW'(1))};
			end
			SQ_SHIFT_WR: begin
				mem_we  = 1'b1;
				idx_inc = 1'b1;
			end
			SQ_RESP: res_valid = 1'b1;
			default: idle = 1'b0;
		endcase
		mem_wdata = EXT_W'(wr_ext);
	end

	// Control registers: state, extent counts and the global free counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SQ_IDLE;
			fc_q    <= 32'd0;
			for (int i = 0; i < GROUP_COUNT; i++) begin
				cnt_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (cnt_we) cnt_q[grp] <= cnt_val;
			if (cfg_wr_en) begin
				fc_q <= cfg_wr_data;
			end else if (fc_inc && fc_q != 32'hFFFF_FFFF) begin
				fc_q <= fc_q + 32'd1;
			end else if (fc_dec && fc_q != 32'd0) begin
				fc_q <= fc_q - 32'd1;
			end
		end
	end

	// Payload registers for the request in flight.
	always_ff @(posedge clk) begin
		if (start && idle) req_q <= req;
		if (st_ld) status_q <= st_val;
		if (blk_ld) blk_q <= blk_val;
		if (idx_clr) begin
			idx_q <= '0;
		end else if (idx_inc) begin
			idx_q <= idx_q + IW'(1);
		end
	end

	assign res.status      = status_q;
	assign res.alloc_block = blk_q;
	assign res.free_count  = fc_q;

`ifndef SYNTH
	// A scan read never goes past the end of the group's list.
	a_scan_in_list: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == SQ_SCAN_RD) |-> (idx_x < n_x))
		else $error("scan read beyond extent count");

	// The extent count of a group being scanned never exceeds the list size.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == SQ_SCAN_CHK) |-> (n_x <= XW'(MAX_EXTENTS)))
		else $error("extent count above list size");

	// The memory is never read and written in the same cycle.
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && mem_re))
		else $error("memory read and write overlap");

	// A shift read is always followed by the write of the slot below it.
	a_shift_pair: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == SQ_SHIFT_RD) |=> (state_q == SQ_SHIFT_WR && mem_we))
		else $error("shift read without write back");
`endif

endmodule

`default_nettype wire

// ===== design/extent_list_block_allocator_core.sv =====
// Top level of the first-fit extent list block allocator.
// Instantiates elba_seq and elba_ext_ram; depends on elba_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one request word: op, ag_index,
//   block_number and group_size. Output channel (out_valid/out_ready) carries
//   one result word per request: status, alloc_block and free_count.
//   cfg_wr_en with cfg_wr_data loads the global free counter; write it only
//   while no request is in flight.
//   One request is worked on at a time; the next is taken once the sequencer
//   has handed its result on and is idle again. Init, free, bad group, the
//   unused op and alloc on an empty list go from dispatch straight to the
//   result. Alloc otherwise reads and checks extents in turn while looking for
//   a non-empty one, then shifts the later extents down one place when the
//   chosen extent runs empty; every extent costs one read and one check (or
//   write) on the extent memory, so a full list takes the longest.
//   A finished word waits in the output register; the next request is taken
//   meanwhile, and the sequencer holds its result until that register frees.
//   Reset clears every group's extent count and sets the free counter to 0.
`default_nettype none

module extent_list_block_allocator_core #(
	parameter int unsigned GROUP_COUNT = 4,
	parameter int unsigned MAX_EXTENTS = 64
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_ready,
	input  wire  [1:0]  op,
	input  wire  [3:0]  ag_index,
	input  wire  [31:0] block_number,
	input  wire  [31:0] group_size,
	output logic        out_valid,
	input  wire         out_ready,
	output logic [2:0]  status,
	output logic [31:0] alloc_block,
	output logic [31:0] free_count,
	input  wire         cfg_wr_en,
	input  wire  [31:0] cfg_wr_data
);
	import elba_pkg::*;

	localparam int unsigned IW    = $clog2(MAX_EXTENTS);
	localparam int unsigned GW    = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;
	localparam int unsigned AW    = GW + IW;
	localparam int unsigned DEPTH = GROUP_COUNT * (2 ** IW);

	req_t           req;
	result_t        res;
	logic           seq_idle, res_valid, res_ready;
	logic           mem_we, mem_re;
	logic [AW-1:0]  mem_waddr, mem_raddr;
	logic [EXT_W-1:0] mem_wdata, mem_rdata;
	logic           out_valid_q;
	result_t        out_q;

	assign req.op           = op;
	assign req.ag_index     = ag_index;
	assign req.block_number = block_number;
	assign req.group_size   = group_size;

	assign in_ready  = seq_idle;
	assign res_ready = !out_valid_q || out_ready;

	elba_seq #(
		.GROUP_COUNT (GROUP_COUNT),
		.MAX_EXTENTS (MAX_EXTENTS),
		.AW          (AW)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (in_valid),
		.req         (req),
		.idle        (seq_idle),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res         (res),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.mem_we      (mem_we),
		.mem_waddr   (mem_waddr),
		.mem_wdata   (mem_wdata),
		.mem_re      (mem_re),
		.mem_raddr   (mem_raddr),
		.mem_rdata   (mem_rdata)
	);

	elba_ext_ram #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (res_valid && res_ready) out_q <= res;
	end

	assign out_valid   = out_valid_q;
	assign status      = out_q.status;
	assign alloc_block = out_q.alloc_block;
	assign free_count  = out_q.free_count;

`ifndef SYNTH
	// Only one request is in flight: accepting one drops ready.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("second request accepted while busy");

	// A result moves into the output register only when that register is free.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> $stable(out_q))
		else $error("output word overwritten while stalled");

	// A stalled result word stays offered until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid)
		else $error("output word dropped while stalled");
`endif

endmodule

`default_nettype wire
